[sv/rcfr_pkg.sv]
package rcfr_pkg;

    localparam logic [7:0]  HEADER_BYTE   = 8'h66;
    localparam logic [7:0]  TRAILER_BYTE  = 8'h99;
    localparam logic [3:0]  FRAME_LEN     = 4'd8;
    localparam logic [10:0] CHAN_BASE     = 11'd1000;
    localparam logic [7:0]  AUX_MAX       = 8'd128;
    localparam logic [7:0]  TIMEOUT_RESET = 8'd30;
    localparam int          NUM_CHAN      = 4;
    localparam int          NUM_FBYTES    = 5;

    // channel slots in the channel register file
    localparam int CH_ROLL     = 0;
    localparam int CH_PITCH    = 1;
    localparam int CH_THROTTLE = 2;
    localparam int CH_YAW      = 3;

    // aux command codes
    localparam logic [7:0] CMD_1     = 8'd1;
    localparam logic [7:0] CMD_2     = 8'd2;
    localparam logic [7:0] CMD_ESTOP = 8'd4;
    localparam logic [7:0] CMD_8     = 8'd8;
    localparam logic [7:0] CMD_16    = 8'd16;
    localparam logic [7:0] CMD_128   = 8'd128;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef logic [10:0] t_chan;

    // parser status handed to the watchdog
    typedef struct packed {
        logic       frame_ok;
        logic [7:0] aux;
    } t_frame_status;

    typedef struct packed {
        logic       connected;
        logic       command_event;
        logic       emergency_stop;
        logic [7:0] frames_seen;
    } t_link_status;

    // floor(b * 1000 / 256) + 1000
    function automatic t_chan scale_channel(input logic [7:0] b);
        logic [17:0] p;
        p = {10'd0, b} * 18'd1000;
        return {1'b0, p[17:8]} + CHAN_BASE;
    endfunction

    function automatic logic known_command(input logic [7:0] a);
        return a == CMD_1 || a == CMD_2 || a == CMD_ESTOP || a == CMD_8
            || a == CMD_16 || a == CMD_128;
    endfunction

endpackage

[sv/rcfr_parser.sv]
module rcfr_parser
    import rcfr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  logic          i_mode,
    input  logic [7:0]    i_byte,
    output t_chan         o_chan_next [NUM_CHAN],
    output t_frame_status o_cur_status,
    output logic          o_frame_ok,
    output logic [7:0]    o_aux_next
);

    logic       r_in_frame, n_in_frame;
    logic [3:0] r_count, n_count;
    logic [7:0] r_fbytes [NUM_FBYTES];
    t_chan      r_chan [NUM_CHAN];
    t_chan      n_chan [NUM_CHAN];
    logic [7:0] r_aux, n_aux;
    logic       fb_we;
    logic [2:0] fb_idx;
    logic [3:0] count_inc;
    logic       good;

    assign count_inc = r_count + 4'd1;
    assign fb_idx    = 3'(r_count - 4'd1);

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_chan     = r_chan;
        n_aux      = r_aux;
        fb_we      = 1'b0;
        good       = 1'b0;
        if (i_mode == MODE_BYTE) begin
            if (!r_in_frame) begin
                if (i_byte == HEADER_BYTE) begin
                    n_in_frame = 1'b1;
                    n_count    = 4'd1;
                end
            end else begin
                fb_we   = (r_count >= 4'd1) && (r_count <= 4'(NUM_FBYTES));
                n_count = count_inc;
                if (count_inc >= FRAME_LEN) begin
                    // trailer position: accept or drop, then hunt again
                    if (i_byte == TRAILER_BYTE) begin
                        good = 1'b1;
                        for (int i = 0; i < NUM_CHAN; i++) begin
                            n_chan[i] = scale_channel(r_fbytes[i]);
                        end
                        n_aux = (r_fbytes[4] > AUX_MAX) ? AUX_MAX : r_fbytes[4];
                    end
                    n_in_frame = 1'b0;
                    n_count    = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= 4'd0;
            r_aux      <= 8'd0;
            for (int i = 0; i < NUM_CHAN; i++) begin
                r_chan[i] <= CHAN_BASE;
            end
        end else if (i_advance) begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_aux      <= n_aux;
            r_chan     <= n_chan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && fb_we) begin
            r_fbytes[fb_idx] <= i_byte;
        end
    end

    assign o_chan_next           = n_chan;
    assign o_aux_next            = n_aux;
    assign o_frame_ok            = good;
    assign o_cur_status.frame_ok = good;
    assign o_cur_status.aux      = r_aux;

endmodule

[sv/rcfr_watchdog.sv]
module rcfr_watchdog
    import rcfr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  logic          i_mode,
    input  t_frame_status i_status,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_cfg_data,
    output t_link_status  o_link_next
);

    logic [7:0] r_timeout;
    logic [7:0] r_silence, n_silence;
    logic       r_link, n_link;
    logic [7:0] r_last_aux, n_last_aux;
    logic [7:0] r_frames, n_frames;
    logic       cmd, estop;
    logic [7:0] sil_inc;

    assign sil_inc = (r_silence < 8'd255) ? r_silence + 8'd1 : r_silence;

    always_comb begin
        n_silence  = r_silence;
        n_link     = r_link;
        n_last_aux = r_last_aux;
        n_frames   = r_frames;
        cmd        = 1'b0;
        estop      = 1'b0;
        if (i_mode == MODE_TICK) begin
            n_silence = sil_inc;
            if (sil_inc == 8'd1) begin
                n_link   = 1'b1;
                n_frames = r_frames + 8'd1;
                if (r_last_aux != i_status.aux) begin
                    n_last_aux = i_status.aux;
                    cmd        = known_command(i_status.aux);
                    estop      = i_status.aux == CMD_ESTOP;
                end
            end
            if (sil_inc >= r_timeout) begin
                n_silence = 8'd2;
                n_link    = 1'b0;
            end
        end else if (i_status.frame_ok) begin
            n_silence = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence  <= 8'd0;
            r_link     <= 1'b0;
            r_last_aux <= 8'd0;
            r_frames   <= 8'd0;
        end else if (i_advance) begin
            r_silence  <= n_silence;
            r_link     <= n_link;
            r_last_aux <= n_last_aux;
            r_frames   <= n_frames;
        end
    end

    assign o_link_next.connected      = n_link;
    assign o_link_next.command_event  = cmd;
    assign o_link_next.emergency_stop = estop;
    assign o_link_next.frames_seen    = n_frames;

endmodule

[sv/rc_frame_receiver_link_watchdog.sv]
// rc frame receiver with link watchdog
// input stream s_axis: one word per received byte or per periodic tick;
//   tuser = mode (0 byte, 1 tick), tdata = byte value
// output stream m_axis: one result word per input word, carrying the channel
//   values of the last good frame, aux flags and the link status after that word
// config channel: i_cfg_valid / o_cfg_ready / i_cfg_data writes timeout_ticks;
//   always ready, write only while the block is idle
// path: an accepted word is held in the input register, then a single-pass
//   update writes the result register
// throughput: one word per cycle unless m_axis stalls; a word's state update is
//   one combinational pass from input register to state and result registers
// reset (i_rst_n low, synchronous): parser hunts for a header, channels read
//   1000, aux 0, link down, counters cleared, timeout back to 30
// a stalled m_axis holds the result; one more word is then held in the input
//   register and s_axis_tready drops until the result is taken
module rc_frame_receiver_link_watchdog
    import rcfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_value[7:0]
    input  logic        s_axis_tuser,   // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // throttle[10:0], yaw_cmd[21:11], roll_cmd[32:22], pitch_cmd[43:33],
    // aux_flags[51:44], frame_ok[52], connected[53], command_event[54],
    // emergency_stop[55], frames_seen[63:56]
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic          r_in_valid;
    logic          r_in_mode;
    logic [7:0]    r_in_byte;
    logic          r_out_valid;
    logic [63:0]   r_out_data;
    logic          advance;
    t_chan         chan_next [NUM_CHAN];
    t_frame_status cur_status;
    logic          frame_ok;
    logic [7:0]    aux_next;
    t_link_status  link_next;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    rcfr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_mode       (r_in_mode),
        .i_byte       (r_in_byte),
        .o_chan_next  (chan_next),
        .o_cur_status (cur_status),
        .o_frame_ok   (frame_ok),
        .o_aux_next   (aux_next)
    );

    rcfr_watchdog u_watchdog (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_mode      (r_in_mode),
        .i_status    (cur_status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_link_next (link_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {link_next.frames_seen, link_next.emergency_stop,
                           link_next.command_event, link_next.connected, frame_ok,
                           aux_next, chan_next[CH_PITCH], chan_next[CH_ROLL],
                           chan_next[CH_YAW], chan_next[CH_THROTTLE]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
